FILE: rtl/lvwd_pkg.sv
package lvwd_pkg;

    // Code and dictionary geometry
    localparam int CODE_W      = 11;
    localparam int TABLE_DEPTH = 2048;
    localparam int STACK_DEPTH = 2048;
    localparam int CHUNK_BYTES = 32;

    localparam logic [3:0]        START_WIDTH       = 4'd9;
    localparam logic [3:0]        MAX_WIDTH         = 4'd11;
    localparam logic [CODE_W-1:0] CLEAR_CODE        = 11'h100;
    localparam logic [CODE_W-1:0] END_CODE          = 11'h101;
    localparam logic [11:0]       FIRST_AFTER_CLEAR = 12'd258;
    localparam logic [11:0]       FIRST_AT_START    = 12'd257;
    localparam logic [11:0]       NEXT_MAX          = 12'd4095;
    localparam logic [5:0]        CHUNK_FULL        = 6'd32;
    localparam logic [6:0]        MAX_RESULTS       = 7'd64;

    typedef enum logic [1:0] {
        PH_PRIME,
        PH_LITERAL,
        PH_DECODE,
        PH_STOPPED
    } phase_t;

    typedef enum logic [1:0] {
        ST_DECODING,
        ST_END,
        ST_LENGTH,
        ST_INVALID
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXTRACT,
        S_DISPATCH,
        S_WALK,
        S_POP_WAIT,
        S_POP,
        S_UPDATE,
        S_FLUSH
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic    accept;
        logic    take_code;
        logic    prime;
        logic    literal;
        logic    clear;
        logic    stop;
        status_t stop_code;
        logic    start_walk;
        logic    kwkwk;
        logic    walk_push;
        logic    walk_root;
        logic    pop;
        logic    update;
        logic    emit_final;
    } lvwd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        phase_t phase;
        logic   code_avail;
        logic   len_reached;
        logic   code_is_end;
        logic   code_is_clear;
        logic   code_gt_nf;
        logic   code_eq_nf;
        logic   walk_gt_root;
        logic   sp_full;
        logic   sp_zero;
        logic   chunk_full;
        logic   out_free;
        logic   need_final;
    } lvwd_stat_t;

endpackage

FILE: rtl/lvwd_ctrl.sv
module lvwd_ctrl
    import lvwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  lvwd_stat_t stat,
    output lvwd_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXTRACT;
                end
            end
            S_EXTRACT:
            begin
                if (stat.phase == PH_STOPPED || !stat.code_avail)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.take_code = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_EXTRACT;
                case (stat.phase)
                    PH_PRIME:
                    begin
                        cmd.prime = 1'b1;
                    end
                    PH_LITERAL:
                    begin
                        if (stat.len_reached)
                        begin
                            cmd.stop      = 1'b1;
                            cmd.stop_code = ST_LENGTH;
                        end
                        else if (stat.chunk_full && !stat.out_free)
                        begin
                            state_next = S_DISPATCH;
                        end
                        else
                        begin
                            cmd.literal = 1'b1;
                        end
                    end
                    PH_DECODE:
                    begin
                        if (stat.len_reached)
                        begin
                            cmd.stop      = 1'b1;
                            cmd.stop_code = ST_LENGTH;
                        end
                        else if (stat.code_is_end)
                        begin
                            cmd.stop      = 1'b1;
                            cmd.stop_code = ST_END;
                        end
                        else if (stat.code_is_clear)
                        begin
                            cmd.clear = 1'b1;
                        end
                        else if (stat.code_gt_nf)
                        begin
                            cmd.stop      = 1'b1;
                            cmd.stop_code = ST_INVALID;
                        end
                        else
                        begin
                            cmd.start_walk = 1'b1;
                            cmd.kwkwk      = stat.code_eq_nf;
                            state_next     = S_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_EXTRACT;
                    end
                endcase
            end
            S_WALK:
            begin
                // One dictionary entry per cycle, guard the stack limit
                if (stat.sp_full)
                begin
                    cmd.stop      = 1'b1;
                    cmd.stop_code = ST_INVALID;
                    state_next    = S_EXTRACT;
                end
                else if (stat.walk_gt_root)
                begin
                    cmd.walk_push = 1'b1;
                end
                else
                begin
                    cmd.walk_root = 1'b1;
                    state_next    = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                if (stat.sp_zero || stat.len_reached)
                begin
                    state_next = S_UPDATE;
                end
                else if (!(stat.chunk_full && !stat.out_free))
                begin
                    cmd.pop = 1'b1;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (stat.len_reached)
                begin
                    cmd.stop      = 1'b1;
                    cmd.stop_code = ST_LENGTH;
                end
                state_next = S_EXTRACT;
            end
            S_FLUSH:
            begin
                if (!stat.need_final)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/lvwd_datapath.sv
module lvwd_datapath
    import lvwd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [263:0] m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  lvwd_cmd_t    cmd,
    output lvwd_stat_t   stat
);

    // Stream and dictionary state
    logic [23:0]       buf_reg,   buf_next;
    logic [4:0]        bits_reg,  bits_next;
    logic [3:0]        width_reg, width_next;
    logic [11:0]       nf_reg,    nf_next;
    logic [CODE_W-1:0] prev_reg,  prev_next;
    logic [7:0]        fcl_reg,   fcl_next;
    phase_t            phase_reg, phase_next;
    logic [15:0]       bw_reg,    bw_next;
    logic [15:0]       len_reg,   len_next;
    status_t           step_st_reg, step_st_next;
    logic [CODE_W-1:0] code_reg,  code_next;
    logic [CODE_W-1:0] walk_reg,  walk_next;
    logic [11:0]       sp_reg,    sp_next;
    logic [7:0]        root_reg,  root_next;
    logic [5:0]        cnt_reg,   cnt_next;
    logic [6:0]        res_reg,   res_next;
    logic              m_valid_reg, m_valid_next;

    // Payload registers
    logic [7:0]   chunk_reg [CHUNK_BYTES];
    logic [255:0] m_data_reg;
    logic [5:0]   m_cnt_reg;
    logic         m_last_reg;
    status_t      m_st_reg;

    // Memories
    logic [CODE_W+7:0] dict_mem [TABLE_DEPTH];
    logic [CODE_W+7:0] dict_q_reg;
    logic [7:0]        stk_mem [STACK_DEPTH];
    logic [7:0]        stk_q_reg;

    logic              dict_we;
    logic              stk_we;
    logic [10:0]       stk_waddr;
    logic [7:0]        stk_wdata;
    logic [10:0]       stk_raddr;

    logic              put;
    logic [7:0]        put_byte;
    logic [4:0]        put_idx;
    logic              emit_mid;
    logic              out_load;
    logic              out_free;
    logic [255:0]      chunk_data;

    assign out_free = !m_valid_reg || m_tready;
    assign put      = cmd.literal || cmd.pop;
    assign put_byte = cmd.literal ? code_reg[7:0] : stk_q_reg;
    assign put_idx  = (cnt_reg == CHUNK_FULL) ? 5'd0 : cnt_reg[4:0];
    assign emit_mid = put && (cnt_reg == CHUNK_FULL);
    assign out_load = (emit_mid || cmd.emit_final) && (res_reg < MAX_RESULTS);
    assign stk_raddr = 11'(sp_next - 12'd1);

    // Status toward the controller
    always_comb
    begin
        stat.phase         = phase_reg;
        stat.code_avail    = bits_reg >= 5'(width_reg);
        stat.len_reached   = bw_reg >= len_reg;
        stat.code_is_end   = code_reg == END_CODE;
        stat.code_is_clear = code_reg == CLEAR_CODE;
        stat.code_gt_nf    = {1'b0, code_reg} > nf_reg;
        stat.code_eq_nf    = {1'b0, code_reg} == nf_reg;
        stat.walk_gt_root  = walk_reg[CODE_W-1:8] != '0;
        stat.sp_full       = sp_reg[11];
        stat.sp_zero       = sp_reg == '0;
        stat.chunk_full    = cnt_reg == CHUNK_FULL;
        stat.out_free      = out_free;
        stat.need_final    = (cnt_reg != '0) || (step_st_reg != ST_DECODING);
    end

    // Mask bytes past the fill count
    always_comb
    begin
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            chunk_data[8*i +: 8] = (6'(i) < cnt_reg) ? chunk_reg[i] : 8'd0;
        end
    end

    // Next-state logic for all commands
    always_comb
    begin
        buf_next     = buf_reg;
        bits_next    = bits_reg;
        width_next   = width_reg;
        nf_next      = nf_reg;
        prev_next    = prev_reg;
        fcl_next     = fcl_reg;
        phase_next   = phase_reg;
        bw_next      = bw_reg;
        len_next     = len_reg;
        step_st_next = step_st_reg;
        code_next    = code_reg;
        walk_next    = walk_reg;
        sp_next      = sp_reg;
        root_next    = root_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        dict_we      = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = sp_reg[10:0];
        stk_wdata    = dict_q_reg[7:0];

        if (cfg_wr_en)
        begin
            len_next = cfg_wr_data;
        end

        // Take in a byte, restarting the stream if flagged
        if (cmd.accept)
        begin
            step_st_next = ST_DECODING;
            res_next     = '0;
            if (s_tuser[0])
            begin
                width_next = START_WIDTH;
                nf_next    = FIRST_AT_START;
                prev_next  = '0;
                fcl_next   = '0;
                phase_next = PH_PRIME;
                bw_next    = '0;
                buf_next   = '0;
                bits_next  = '0;
            end
            if (s_tuser[0] || phase_reg != PH_STOPPED)
            begin
                buf_next  = (s_tuser[0] ? 24'd0 : buf_reg)
                          | (24'(s_tdata) << (s_tuser[0] ? 5'd0 : bits_reg));
                bits_next = (s_tuser[0] ? 5'd0 : bits_reg) + 5'd8;
            end
        end

        // Pull one code from the low end of the bit buffer
        if (cmd.take_code)
        begin
            code_next = CODE_W'(buf_reg & ((24'd1 << width_reg) - 24'd1));
            buf_next  = buf_reg >> width_reg;
            bits_next = bits_reg - 5'(width_reg);
        end

        if (cmd.prime)
        begin
            prev_next  = code_reg;
            fcl_next   = code_reg[7:0];
            phase_next = PH_DECODE;
        end

        if (cmd.literal)
        begin
            prev_next  = code_reg;
            fcl_next   = code_reg[7:0];
            phase_next = PH_DECODE;
            if (16'(bw_reg + 16'd1) >= len_reg)
            begin
                phase_next   = PH_STOPPED;
                step_st_next = ST_LENGTH;
            end
        end

        if (cmd.clear)
        begin
            nf_next    = FIRST_AFTER_CLEAR;
            width_next = START_WIDTH;
            phase_next = PH_LITERAL;
        end

        // Chain walk onto the reverse stack
        if (cmd.start_walk)
        begin
            if (cmd.kwkwk)
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = fcl_reg;
                sp_next   = 12'd1;
                walk_next = prev_reg;
            end
            else
            begin
                sp_next   = '0;
                walk_next = code_reg;
            end
        end

        if (cmd.walk_push)
        begin
            stk_we    = 1'b1;
            stk_wdata = dict_q_reg[7:0];
            sp_next   = sp_reg + 12'd1;
            walk_next = dict_q_reg[CODE_W+7:8];
        end

        if (cmd.walk_root)
        begin
            stk_we    = 1'b1;
            stk_wdata = walk_reg[7:0];
            root_next = walk_reg[7:0];
            sp_next   = sp_reg + 12'd1;
        end

        if (cmd.pop)
        begin
            sp_next = sp_reg - 12'd1;
        end

        // Append one byte to the chunk, spilling a full one first
        if (put)
        begin
            bw_next  = bw_reg + 16'd1;
            cnt_next = (cnt_reg == CHUNK_FULL) ? 6'd1 : cnt_reg + 6'd1;
        end

        if (cmd.emit_final)
        begin
            cnt_next = '0;
        end

        if (out_load)
        begin
            res_next = res_reg + 7'd1;
        end

        // Add the new entry and grow the code width early
        if (cmd.update)
        begin
            if (nf_reg > ((12'd1 << width_reg) - 12'd2) && width_reg < MAX_WIDTH)
            begin
                width_next = width_reg + 4'd1;
            end
            dict_we   = !nf_reg[11];
            nf_next   = (nf_reg < NEXT_MAX) ? nf_reg + 12'd1 : nf_reg;
            prev_next = code_reg;
            fcl_next  = root_reg;
        end

        if (cmd.stop)
        begin
            phase_next   = PH_STOPPED;
            step_st_next = cmd.stop_code;
        end
    end

    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            bits_reg    <= '0;
            width_reg   <= START_WIDTH;
            nf_reg      <= FIRST_AT_START;
            prev_reg    <= '0;
            fcl_reg     <= '0;
            phase_reg   <= PH_PRIME;
            bw_reg      <= '0;
            len_reg     <= '0;
            step_st_reg <= ST_DECODING;
            code_reg    <= '0;
            walk_reg    <= '0;
            sp_reg      <= '0;
            root_reg    <= '0;
            cnt_reg     <= '0;
            res_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg     <= buf_next;
            bits_reg    <= bits_next;
            width_reg   <= width_next;
            nf_reg      <= nf_next;
            prev_reg    <= prev_next;
            fcl_reg     <= fcl_next;
            phase_reg   <= phase_next;
            bw_reg      <= bw_next;
            len_reg     <= len_next;
            step_st_reg <= step_st_next;
            code_reg    <= code_next;
            walk_reg    <= walk_next;
            sp_reg      <= sp_next;
            root_reg    <= root_next;
            cnt_reg     <= cnt_next;
            res_reg     <= res_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Chunk bytes and output payload
    always_ff @(posedge clk)
    begin
        if (put)
        begin
            chunk_reg[put_idx] <= put_byte;
        end
        if (out_load)
        begin
            m_data_reg <= chunk_data;
            m_cnt_reg  <= cnt_reg;
            m_last_reg <= cmd.emit_final;
            m_st_reg   <= cmd.emit_final ? step_st_reg : ST_DECODING;
        end
    end

    // Dictionary: prefix and suffix per entry, read follows the walk
    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[nf_reg[10:0]] <= {prev_reg, root_reg};
        end
        dict_q_reg <= dict_mem[walk_next];
    end

    // Reverse stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_q_reg <= stk_mem[stk_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_cnt_reg, m_data_reg};
    assign m_tuser  = m_st_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        width_reg >= START_WIDTH && width_reg <= MAX_WIDTH)
        else $error("code width out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output register loaded while a result is stalled");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= 12'd2048)
        else $error("reverse stack pointer beyond depth");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= 5'd18 && cnt_reg <= CHUNK_FULL)
        else $error("bit buffer or chunk count overflow");
`endif

endmodule

FILE: rtl/lzw_variable_width_decoder.sv
// LZW decoder, variable code width 9 to 11 bits, codes packed LSB first.
// Input channel s_*: one compressed byte per transfer in s_tdata; s_tuser
// set restarts the bit buffer, width, next free code and byte count first.
// Output channel m_*: chunks of up to 32 decoded bytes in m_tdata, byte 0
// lowest, with the byte count above them; m_tlast marks the final chunk
// caused by an input byte and m_tuser carries the stop status on it.
// Configuration: cfg_wr_en/cfg_wr_data set the number of bytes to produce.
// Operation: an input byte is accepted, each code it completes is taken and
// dispatched, and a last look that finds no code leads to the flush; a
// string is made by walking the dictionary chain one entry per cycle into a
// reverse stack and popping it one byte per cycle unless the output stalls.
// s_tready is high only while the decoder waits for its next byte.
// A stalled receiver holds the output register; decoding and the input
// stall whenever a chunk must leave while a previous result is still held.
// Reset clears the stream state to the start of a stream and the length to
// zero; dictionary contents are undefined until written by decoding.
module lzw_variable_width_decoder
    import lvwd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // stream_byte
    input  logic [0:0]   s_tuser,   // first_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [263:0] m_tdata,   // bytes_low, bytes_mid_low, bytes_mid_high,
                                    // bytes_high, byte_count, zero pad
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast,   // last_of_run
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);

    lvwd_cmd_t  cmd;
    lvwd_stat_t stat;

    lvwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lvwd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
